FILE: sv/lmlt_pkg.sv
// lcd mode and line timer: shared types, mode codes, line limits and reset values
// no dependencies; used by every module of the block
package lmlt_pkg;

    localparam int unsigned SPAN_W  = 10;
    localparam int unsigned CYCLE_W = 32;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;

    // mode codes as seen on mode_bits
    localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HBLANK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OAM      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER = 2'd3;

    localparam logic [SPAN_W-1:0] HBLANK_RST   = 10'd204;
    localparam logic [SPAN_W-1:0] VBLANK_RST   = 10'd456;
    localparam logic [SPAN_W-1:0] OAM_RST      = 10'd80;
    localparam logic [SPAN_W-1:0] TRANSFER_RST = 10'd172;

    typedef struct packed {
        logic [SPAN_W-1:0] hblank_cycles;
        logic [SPAN_W-1:0] vblank_line_cycles;
        logic [SPAN_W-1:0] oam_scan_cycles;
        logic [SPAN_W-1:0] transfer_cycles;
    } cfg_t;

    typedef struct packed {
        logic [CYCLE_W-1:0] cycle_count;
        logic               lcd_enable;
        logic               hblank_irq_en;
        logic               vblank_irq_en;
        logic               oam_irq_en;
        logic               lyc_irq_en;
        logic [LINE_W-1:0]  compare_line;
    } step_in_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LINE_W-1:0]  line;
        logic [CYCLE_W-1:0] mode_start;
        logic [LINE_W-1:0]  last_compared;
        logic               stat_active;
        logic               coincidence;
    } state_t;

    typedef struct packed {
        logic [LINE_W-1:0] current_line;
        logic [MODE_W-1:0] mode_bits;
        logic              coincidence;
        logic              stat_irq;
        logic              vblank_irq;
        logic              dma_start;
        logic              render_valid;
        logic [LINE_W-1:0] render_index;
        logic              frame_done;
    } result_t;

endpackage

FILE: sv/lmlt_step.sv
// lcd mode and line timer: next-state and result logic for one step
// depends on lmlt_pkg
module lmlt_step
(
    input  lmlt_pkg::cfg_t     cfg,
    input  lmlt_pkg::state_t   state,
    input  lmlt_pkg::step_in_t step_in,
    output lmlt_pkg::state_t   state_next,
    output lmlt_pkg::result_t  result
);

    logic                             cond;
    logic                             lyc_check;
    logic                             lyc_match;
    logic [lmlt_pkg::SPAN_W-1:0]      span;
    logic [lmlt_pkg::CYCLE_W-1:0]     elapsed;
    logic                             span_done;
    logic [lmlt_pkg::LINE_W-1:0]      line_inc;

    always_comb
    begin
        case (state.mode)
            lmlt_pkg::MODE_HBLANK:   span = cfg.hblank_cycles;
            lmlt_pkg::MODE_VBLANK:   span = cfg.vblank_line_cycles;
            lmlt_pkg::MODE_OAM:      span = cfg.oam_scan_cycles;
            default:                 span = cfg.transfer_cycles;
        endcase
    end

    assign elapsed   = step_in.cycle_count - state.mode_start;
    assign span_done = elapsed >= {{(lmlt_pkg::CYCLE_W-lmlt_pkg::SPAN_W){1'b0}}, span};
    assign line_inc  = state.line + 8'd1;
    assign lyc_check = step_in.lyc_irq_en && (state.line != state.last_compared);
    assign lyc_match = lyc_check && (state.line == step_in.compare_line);

    always_comb
    begin
        state_next = state;
        result     = '0;
        cond       = 1'b0;

        if (!step_in.lcd_enable)
        begin
            // display off: line forced to zero, everything else held
            state_next.line    = '0;
            result.coincidence = state.coincidence;
        end
        else
        begin
            cond = (step_in.oam_irq_en    && state.mode == lmlt_pkg::MODE_OAM)
                || (step_in.hblank_irq_en && state.mode == lmlt_pkg::MODE_HBLANK)
                || (step_in.vblank_irq_en && state.mode == lmlt_pkg::MODE_VBLANK)
                || lyc_match;
            if (lyc_check)
            begin
                state_next.last_compared = state.line;
                state_next.coincidence   = lyc_match;
            end
            result.stat_irq        = cond && !state.stat_active;
            state_next.stat_active = cond;

            if (span_done)
            begin
                state_next.mode_start = step_in.cycle_count;
                case (state.mode)
                    lmlt_pkg::MODE_OAM:
                    begin
                        state_next.mode = lmlt_pkg::MODE_TRANSFER;
                    end
                    lmlt_pkg::MODE_TRANSFER:
                    begin
                        state_next.mode  = lmlt_pkg::MODE_HBLANK;
                        result.dma_start = 1'b1;
                    end
                    lmlt_pkg::MODE_HBLANK:
                    begin
                        if (state.line < lmlt_pkg::VISIBLE_LINES)
                        begin
                            result.render_valid = 1'b1;
                            result.render_index = state.line;
                        end
                        state_next.line = line_inc;
                        if (line_inc == lmlt_pkg::VISIBLE_LINES)
                        begin
                            state_next.mode   = lmlt_pkg::MODE_VBLANK;
                            result.vblank_irq = 1'b1;
                        end
                        else
                        begin
                            state_next.mode = lmlt_pkg::MODE_OAM;
                        end
                    end
                    default:
                    begin
                        state_next.line = line_inc;
                        if (line_inc > lmlt_pkg::LAST_LINE)
                        begin
                            state_next.mode   = lmlt_pkg::MODE_OAM;
                            state_next.line   = '0;
                            result.frame_done = 1'b1;
                        end
                    end
                endcase
            end

            result.current_line = state_next.line;
            result.mode_bits    = state_next.mode;
            result.coincidence  = state_next.coincidence;
        end
    end

endmodule

FILE: sv/lcd_mode_line_timer.sv
// lcd mode and line timer: top level with state, configuration and result registers
// depends on lmlt_pkg and lmlt_step
//
// Usage: each input transfer is one machine-cycle step carrying the free-running
// cycle count, the display enable, the status interrupt enables and the compare
// line. Each step gives exactly one result transfer: line, mode bits, the
// coincidence flag and the interrupt, dma, render and frame-end pulses.
// Each result is registered and shows in the cycle after its step. Throughput is
// one step per cycle unless stalled; the step logic is one 32-bit subtract and
// compare against the current mode span plus small line counter updates.
// in_ready is high while the result register is empty or being emptied, so a
// new step is taken in the same cycle that the previous result is taken.
// If the receiver stalls, the result holds and in_ready drops until it is taken.
// Reset puts the timer in object search at line 0 with all spans at their
// defaults and the output register empty. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at the next edge and are meant for idle time.
module lcd_mode_line_timer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lmlt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmlt_pkg::SPAN_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lmlt_pkg::CYCLE_W-1:0]      cycle_count,
    input  logic                              lcd_enable,
    input  logic                              hblank_irq_en,
    input  logic                              vblank_irq_en,
    input  logic                              oam_irq_en,
    input  logic                              lyc_irq_en,
    input  logic [lmlt_pkg::LINE_W-1:0]       compare_line,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lmlt_pkg::LINE_W-1:0]       current_line,
    output logic [lmlt_pkg::MODE_W-1:0]       mode_bits,
    output logic                              coincidence,
    output logic                              stat_irq,
    output logic                              vblank_irq,
    output logic                              dma_start,
    output logic                              render_valid,
    output logic [lmlt_pkg::LINE_W-1:0]       render_index,
    output logic                              frame_done
);

    lmlt_pkg::cfg_t     cfg_reg;
    lmlt_pkg::state_t   state_reg;
    lmlt_pkg::state_t   state_next;
    lmlt_pkg::step_in_t step_in;
    lmlt_pkg::result_t  result_next;
    lmlt_pkg::result_t  result_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign step_in.cycle_count   = cycle_count;
    assign step_in.lcd_enable    = lcd_enable;
    assign step_in.hblank_irq_en = hblank_irq_en;
    assign step_in.vblank_irq_en = vblank_irq_en;
    assign step_in.oam_irq_en    = oam_irq_en;
    assign step_in.lyc_irq_en    = lyc_irq_en;
    assign step_in.compare_line  = compare_line;

    lmlt_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .step_in    (step_in),
        .state_next (state_next),
        .result     (result_next)
    );

    // result register empties on a transfer out and refills on a transfer in
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hblank_cycles      <= lmlt_pkg::HBLANK_RST;
            cfg_reg.vblank_line_cycles <= lmlt_pkg::VBLANK_RST;
            cfg_reg.oam_scan_cycles    <= lmlt_pkg::OAM_RST;
            cfg_reg.transfer_cycles    <= lmlt_pkg::TRANSFER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmlt_pkg::CFG_HBLANK:   cfg_reg.hblank_cycles      <= cfg_data;
                lmlt_pkg::CFG_VBLANK:   cfg_reg.vblank_line_cycles <= cfg_data;
                lmlt_pkg::CFG_OAM:      cfg_reg.oam_scan_cycles    <= cfg_data;
                lmlt_pkg::CFG_TRANSFER: cfg_reg.transfer_cycles    <= cfg_data;
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= lmlt_pkg::MODE_OAM;
            state_reg.line          <= '0;
            state_reg.mode_start    <= '0;
            state_reg.last_compared <= '0;
            state_reg.stat_active   <= 1'b0;
            state_reg.coincidence   <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_line = result_reg.current_line;
    assign mode_bits    = result_reg.mode_bits;
    assign coincidence  = result_reg.coincidence;
    assign stat_irq     = result_reg.stat_irq;
    assign vblank_irq   = result_reg.vblank_irq;
    assign dma_start    = result_reg.dma_start;
    assign render_valid = result_reg.render_valid;
    assign render_index = result_reg.render_index;
    assign frame_done   = result_reg.frame_done;

endmodule

FILE: sv/lmlt_checker.sv
// lcd mode and line timer: port-level checks over time, bound to the top level
// depends on lmlt_pkg and lcd_mode_line_timer
module lmlt_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [lmlt_pkg::LINE_W-1:0]       current_line,
    input  logic [lmlt_pkg::MODE_W-1:0]       mode_bits,
    input  logic                              vblank_irq,
    input  logic                              dma_start,
    input  logic                              render_valid,
    input  logic [lmlt_pkg::LINE_W-1:0]       render_index,
    input  logic                              frame_done
);

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(current_line)
            && $stable(mode_bits) && $stable(render_index))
        else $error("result changed while stalled");

    // an empty result register never blocks the input side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // the line counter never runs past the last line
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> current_line <= lmlt_pkg::LAST_LINE)
        else $error("line past the last line");

    // pulses match the mode they lead into
    a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (!dma_start || mode_bits == lmlt_pkg::MODE_HBLANK)
            && (!vblank_irq || (mode_bits == lmlt_pkg::MODE_VBLANK
                                && current_line == lmlt_pkg::VISIBLE_LINES))
            && (!frame_done || (mode_bits == lmlt_pkg::MODE_OAM && current_line == '0)))
        else $error("pulse does not match new mode");

    // render requests only name visible lines
    a_render: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (render_valid ? render_index < lmlt_pkg::VISIBLE_LINES
                                    : render_index == '0))
        else $error("bad render index");

endmodule

bind lcd_mode_line_timer lmlt_checker u_lmlt_checker (.*);
